[sv/cts2ms_pkg.sv]
// ============================================================================
// cts2ms_pkg : shared types for the civil timestamp to Unix milliseconds unit
// Holds the stage records that travel between the pipeline modules and the
// month start table of the days-from-civil rule.
// ============================================================================
`default_nettype none

package cts2ms_pkg;

	// Offset kinds carried in the input tuser.
	localparam logic [1:0] OFS_NONE  = 2'd0;
	localparam logic [1:0] OFS_PLUS  = 2'd1;
	localparam logic [1:0] OFS_MINUS = 2'd2;

	// Width of the milliseconds field.
	localparam int unsigned MS_W        = 49;

	// Unpacked input word.
	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [1:0]  offset_kind;
		logic [6:0]  offset_hours;
		logic [6:0]  offset_minutes;
		logic [9:0]  frac_val;
		logic [1:0]  frac_ndig;
	} in_t;

	// After range check, March-based year and month decode.
	typedef struct packed {
		logic        ok;
		logic [13:0] y;
		logic [5:0]  era;
		logic [8:0]  mstart;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [1:0]  okind;
		logic [6:0]  ohours;
		logic [6:0]  ominutes;
		logic [16:0] frac;
	} s1_t;

	// Year of era, day of year, time of day moved to UTC.
	typedef struct packed {
		logic               ok;
		logic [5:0]         era;
		logic [8:0]         yoe;
		logic [8:0]         doy;
		logic signed [19:0] sadj;
		logic [16:0]        frac;
	} s2_t;

	// Day of era.
	typedef struct packed {
		logic               ok;
		logic [5:0]         era;
		logic [17:0]        doe;
		logic signed [19:0] sadj;
		logic [16:0]        frac;
	} s3_t;

	// Days since 1970-01-01.
	typedef struct packed {
		logic               ok;
		logic signed [23:0] days;
		logic signed [19:0] sadj;
		logic [16:0]        frac;
	} s4_t;

	// Seconds since the epoch in UTC.
	typedef struct packed {
		logic               ok;
		logic signed [39:0] secs;
		logic [16:0]        frac;
	} s5_t;

	// Result word.
	typedef struct packed {
		logic            ok;
		logic [MS_W-1:0] ms;
	} s6_t;

	// First day of each month counted from March 1, i.e. (153 * mp + 2) / 5.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/cts2ms_front.sv]
// ============================================================================
// cts2ms_front : stages 1 and 2 of the timestamp pipeline
// Checks field ranges, splits the year into era and year of era, decodes the
// day of year and forms the time of day with the zone offset applied.
// ============================================================================
`default_nettype none

module cts2ms_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire cts2ms_pkg::in_t  in_word,
	output logic                  valid_s2,
	output cts2ms_pkg::s2_t       data_s2
);
	import cts2ms_pkg::*;

	logic valid_s1;
	s1_t  data_s1;
	s1_t  s1_next;
	s2_t  s2_next;

	// Stage 1: range check, year shift for Jan/Feb, era by reciprocal.
	always_comb begin
		logic [9:0]  y16;
		logic [15:0] era_prod;
		logic [3:0]  mp;
		s1_next.ok = (in_word.year >= 14'd1970) &&
			(in_word.month >= 7'd1) && (in_word.month <= 7'd12) &&
			(in_word.day >= 7'd1) && (in_word.day <= 7'd31) &&
			(in_word.hour <= 7'd23) && (in_word.minute <= 7'd59) &&
			(in_word.second <= 7'd60);
		s1_next.y = in_word.year - ((in_word.month <= 7'd2) ? 14'd1 : 14'd0);
		// y / 400 = (y / 16) / 25, and x / 25 = (x * 41) >> 10 for x below 625.
		y16 = s1_next.y[13:4];
		era_prod = 16'(y16) * 16'd41;
		s1_next.era = era_prod[15:10];
		mp = (in_word.month > 7'd2) ? 4'(in_word.month - 7'd3) : 4'(in_word.month + 7'd9);
		s1_next.mstart = month_start(mp);
		s1_next.day = in_word.day;
		s1_next.hour = in_word.hour;
		s1_next.minute = in_word.minute;
		s1_next.second = in_word.second;
		s1_next.okind = in_word.offset_kind;
		s1_next.ohours = in_word.offset_hours;
		s1_next.ominutes = in_word.offset_minutes;
		case (in_word.frac_ndig)
			2'd1:    s1_next.frac = 17'(in_word.frac_val) * 17'd100;
			2'd2:    s1_next.frac = 17'(in_word.frac_val) * 17'd10;
			2'd3:    s1_next.frac = 17'(in_word.frac_val);
			default: s1_next.frac = 17'd0;
		endcase
	end

	// Stage 2: year of era, day of year, seconds of day adjusted to UTC.
	always_comb begin
		logic [13:0] era400;
		logic [13:0] yoe_w;
		logic [19:0] tod;
		logic [19:0] offs;
		era400 = 14'(data_s1.era) * 14'd400;
		yoe_w = data_s1.y - era400;
		tod = 20'(data_s1.hour) * 20'd3600 + 20'(data_s1.minute) * 20'd60 +
			20'(data_s1.second);
		offs = 20'(data_s1.ohours) * 20'd3600 + 20'(data_s1.ominutes) * 20'd60;
		s2_next.ok = data_s1.ok;
		s2_next.era = data_s1.era;
		s2_next.yoe = yoe_w[8:0];
		s2_next.doy = data_s1.mstart + 9'(data_s1.day) - 9'd1;
		case (data_s1.okind)
			OFS_PLUS:  s2_next.sadj = $signed(tod - offs);
			OFS_MINUS: s2_next.sadj = $signed(tod + offs);
			default:   s2_next.sadj = $signed(tod);
		endcase
		s2_next.frac = data_s1.frac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= s1_next;
			data_s2 <= s2_next;
		end
	end

endmodule

`default_nettype wire

[sv/cts2ms_days.sv]
// ============================================================================
// cts2ms_days : stages 3 and 4 of the timestamp pipeline
// Forms the day of era and then the day count relative to 1970-01-01.
// ============================================================================
`default_nettype none

module cts2ms_days (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             valid_s2,
	input  wire cts2ms_pkg::s2_t  data_s2,
	output logic                  valid_s4,
	output cts2ms_pkg::s4_t       data_s4
);
	import cts2ms_pkg::*;

	logic valid_s3;
	s3_t  data_s3;
	s3_t  s3_next;
	s4_t  s4_next;

	// Stage 3: doe = yoe * 365 + yoe / 4 - yoe / 100 + doy.
	always_comb begin
		logic [17:0] cent;
		if (data_s2.yoe >= 9'd300) begin
			cent = 18'd3;
		end else if (data_s2.yoe >= 9'd200) begin
			cent = 18'd2;
		end else if (data_s2.yoe >= 9'd100) begin
			cent = 18'd1;
		end else begin
			cent = 18'd0;
		end
		s3_next.ok = data_s2.ok;
		s3_next.era = data_s2.era;
		s3_next.doe = 18'(data_s2.yoe) * 18'd365 + 18'(data_s2.yoe[8:2]) - cent +
			18'(data_s2.doy);
		s3_next.sadj = data_s2.sadj;
		s3_next.frac = data_s2.frac;
	end

	// Stage 4: days = era * 146097 + doe - 719468.
	always_comb begin
		logic [23:0] era_days;
		era_days = 24'(data_s3.era) * 24'd146097;
		s4_next.ok = data_s3.ok;
		s4_next.days = $signed(era_days + 24'(data_s3.doe) - 24'd719468);
		s4_next.sadj = data_s3.sadj;
		s4_next.frac = data_s3.frac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s3 <= s3_next;
			data_s4 <= s4_next;
		end
	end

endmodule

`default_nettype wire

[sv/cts2ms_scale.sv]
// ============================================================================
// cts2ms_scale : stages 5 and 6 of the timestamp pipeline
// Scales days to seconds, seconds to milliseconds, and zeroes invalid words.
// ============================================================================
`default_nettype none

module cts2ms_scale (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             valid_s4,
	input  wire cts2ms_pkg::s4_t  data_s4,
	output logic                  valid_s6,
	output cts2ms_pkg::s6_t       data_s6
);
	import cts2ms_pkg::*;

	logic valid_s5;
	s5_t  data_s5;
	s5_t  s5_next;
	s6_t  s6_next;

	// Stage 5: seconds = days * 86400 + adjusted time of day.
	always_comb begin
		logic signed [39:0] dext;
		dext = 40'(data_s4.days);
		s5_next.ok = data_s4.ok;
		s5_next.secs = dext * 40'sd86400 + 40'(data_s4.sadj);
		s5_next.frac = data_s4.frac;
	end

	// Stage 6: milliseconds = seconds * 1000 + fraction, modulo 2^49.
	always_comb begin
		logic [MS_W-1:0] sext;
		sext = MS_W'(data_s5.secs);
		s6_next.ok = data_s5.ok;
		s6_next.ms = data_s5.ok ? (sext * MS_W'(1000) + MS_W'(data_s5.frac)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s5 <= s5_next;
			data_s6 <= s6_next;
		end
	end

endmodule

`default_nettype wire

[sv/civil_timestamp_to_unix_ms_unit.sv]
// ============================================================================
// civil_timestamp_to_unix_ms_unit : split ISO 8601 timestamp to Unix ms
// Range checks a split date and time, counts days with the era based
// days-from-civil rule, applies the zone offset and fraction, and returns a
// valid flag with signed UTC milliseconds since 1970-01-01.
// ============================================================================
//
//  Channel  Dir  tdata                                         tuser
//  s_axis   in   date, time, offset magnitude, fraction        offset kind
//  m_axis   out  unix_ms, 49 bit two's complement              valid_res
//
// Six register stages take one word per cycle unless the output stalls; the day
// count chain sets the depth. A result moves through stages 1 to 6 in order and is
// presented from stage 6, where it can be taken when the output is not stalled.
// The asynchronous reset clears only the stage valid bits; data is not reset.
// All stages advance together whenever the output register is empty or being
// taken, so a stall holds every word and every bubble in place.
// ============================================================================
`default_nettype none

module civil_timestamp_to_unix_ms_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// From bit 0 up: year[13:0], month[20:14], day[27:21], hour[34:28],
	// minute[41:35], second[48:42], offset_hours[55:49],
	// offset_minutes[62:56], frac_val[72:63], frac_ndig[74:73],
	// zero fill[79:75].
	input  wire logic [79:0] s_axis_tdata,
	// From bit 0 up: offset_kind[1:0].
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// From bit 0 up: unix_ms[48:0], zero fill[55:49].
	output logic [55:0]      m_axis_tdata,
	// From bit 0 up: valid_res[0].
	output logic [0:0]       m_axis_tuser
);
	import cts2ms_pkg::*;

	logic en;
	in_t  in_word;
	logic valid_s2;
	s2_t  data_s2;
	logic valid_s4;
	s4_t  data_s4;
	logic valid_s6;
	s6_t  data_s6;

	// The whole pipe moves when the output register can take a new word.
	assign en = !valid_s6 || m_axis_tready;
	assign s_axis_tready = en;

	// Unpack the stream word into named fields.
	always_comb begin
		in_word.year = s_axis_tdata[13:0];
		in_word.month = s_axis_tdata[20:14];
		in_word.day = s_axis_tdata[27:21];
		in_word.hour = s_axis_tdata[34:28];
		in_word.minute = s_axis_tdata[41:35];
		in_word.second = s_axis_tdata[48:42];
		in_word.offset_hours = s_axis_tdata[55:49];
		in_word.offset_minutes = s_axis_tdata[62:56];
		in_word.frac_val = s_axis_tdata[72:63];
		in_word.frac_ndig = s_axis_tdata[74:73];
		in_word.offset_kind = s_axis_tuser;
	end

	// Stages 1 and 2: range check, calendar decode and time of day in UTC.
	cts2ms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.in_word  (in_word),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	// Stages 3 and 4: day of era and days since the epoch.
	cts2ms_days u_days (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s4 (valid_s4),
		.data_s4  (data_s4)
	);

	// Stages 5 and 6: seconds, then milliseconds; stage 6 is the output register.
	cts2ms_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s4 (valid_s4),
		.data_s4  (data_s4),
		.valid_s6 (valid_s6),
		.data_s6  (data_s6)
	);

	assign m_axis_tvalid = valid_s6;
	assign m_axis_tdata = {7'd0, data_s6.ms};
	assign m_axis_tuser = data_s6.ok;

endmodule

`default_nettype wire
